FILE: sv/weight_stationary_matrix_multiply_defines.svh
// Assertion macros for the weight-stationary matrix multiply.
// Used by the top level; expects aclk and aresetn in scope.
`ifndef WEIGHT_STATIONARY_MATRIX_MULTIPLY_DEFINES_SVH
`define WEIGHT_STATIONARY_MATRIX_MULTIPLY_DEFINES_SVH

// cond holds -> rule holds in the same cycle
`define WSMM_CHECK(label, cond, rule, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (rule)) \
        else $error(msg);

// cond holds -> rule holds in the following cycle
`define WSMM_CHECK_NEXT(label, cond, rule, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (rule)) \
        else $error(msg);

`endif

FILE: sv/wsmm_pkg.sv
// Shared types and constants for the weight-stationary matrix multiply.
// No dependencies.
`default_nettype none

package wsmm_pkg;

    localparam int VALUE_BITS  = 16;
    localparam int SUM_W       = 40;
    localparam int COL_W       = 6;
    localparam int CMD_W       = 2;
    localparam int ROWS_W      = 13;
    localparam int ROWCNT_W    = 12;
    localparam int M_MAX       = 4096;
    localparam int K_FIELD_MAX = 127;
    localparam int MAX_K_DEF   = 64;
    localparam int MAX_N_DEF   = 64;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 13;

    localparam logic [CMD_W-1:0] CMD_LOAD_B  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_A_ELEM  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ROWS_M      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_N      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_K     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TRANSPOSE_B = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]             command;
        logic signed [VALUE_BITS-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic [COL_W-1:0]        column;
        logic signed [SUM_W-1:0] sum;
        logic                    last_of_row;
        logic                    last_of_matrix;
    } out_item_t;

    typedef struct packed {
        logic step;
        logic clear;
        logic tail;
        logic below;
    } cell_ctl_t;

endpackage

`default_nettype wire

FILE: sv/wsmm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module wsmm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                    aclk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: sv/wsmm_div.sv
// Restoring divider, one quotient bit per cycle; maps a B load position
// to row and column. Depends on nothing.
`default_nettype none

module wsmm_div #(
    parameter int DW = 12,
    parameter int VW = 7
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quot,
    output logic [VW-1:0] rem
);

    localparam int CNTW = $clog2(DW + 1);

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic [DW-1:0]   quo_reg, quo_next;
    logic [VW-1:0]   rem_reg, rem_next;
    logic [VW-1:0]   dvs_reg, dvs_next;

    logic [VW:0]     shifted;
    logic [VW:0]     diff;
    logic            fits;
    logic [DW:0]     qshift;

    always_comb begin
        shifted = {rem_reg, quo_reg[DW-1]};
        diff    = shifted - {1'b0, dvs_reg};
        fits    = shifted >= {1'b0, dvs_reg};
        qshift  = {quo_reg, fits};

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            quo_next = qshift[DW-1:0];
            rem_next = fits ? diff[VW-1:0] : shifted[VW-1:0];
            cnt_next = cnt_reg + CNTW'(1);
            if (cnt_reg == CNTW'(DW - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done = done_reg;
    assign quot = quo_reg;
    assign rem  = rem_reg;

endmodule

`default_nettype wire

FILE: sv/wsmm_cell.sv
// One partial-sum cell of the accumulator chain; shifts toward cell 0.
// Depends on wsmm_pkg.
`default_nettype none

module wsmm_cell
    import wsmm_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  cell_ctl_t        ctl,
    input  logic [SUM_W-1:0] from_right,
    input  logic [SUM_W-1:0] inject,
    output logic [SUM_W-1:0] sum
);

    logic [SUM_W-1:0] sum_reg, sum_next;

    always_comb begin
        sum_next = sum_reg;
        if (ctl.clear) begin
            sum_next = '0;
        end else if (ctl.step && ctl.tail) begin
            sum_next = inject;
        end else if (ctl.step && ctl.below) begin
            sum_next = from_right;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
        end else begin
            sum_reg <= sum_next;
        end
    end

    assign sum = sum_reg;

endmodule

`default_nettype wire

FILE: sv/weight_stationary_matrix_multiply.sv
// Weight-stationary matrix multiply top level: C = A x B in fixed point.
// Depends on wsmm_pkg, wsmm_ram, wsmm_div, wsmm_cell and the defines header.
//
// Usage:
//   cfg_*  : register writes (rows_m, cols_n, inner_k, transpose_b), always ready.
//   s_*    : commands. Load B elements (command 0) first, then stream A
//            row-major (command 1); command 2 restarts all counters and sums.
//   m_*    : result elements of a row, columns 0..n-1, flagged last of row
//            and last of matrix.
//   One item is taken at a time. A B load waits for the restoring divider,
//   which splits the load position (LPW bits, 12 at defaults) into row and
//   column. An A element makes one pass over the columns: one shared
//   multiply-accumulate per column, fed by the weight RAM read port and a
//   two-stage pipe. After the row's last A element the results follow its
//   transfer, one per cycle while the receiver accepts them.
//   Reset clears counters, partial sums and registers (1, 1, 1, 0); the weight
//   store is not cleared. A stalled receiver holds the result register and
//   freezes the final column pass until the transfer completes.
`default_nettype none
`include "weight_stationary_matrix_multiply_defines.svh"

module weight_stationary_matrix_multiply
    import wsmm_pkg::*;
#(
    parameter int MAX_K = MAX_K_DEF,
    parameter int MAX_N = MAX_N_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int KLIM  = (MAX_K < K_FIELD_MAX) ? MAX_K : K_FIELD_MAX;
    localparam int NW    = (MAX_N > 1) ? $clog2(MAX_N) : 1;
    localparam int RW    = (KLIM > 1) ? $clog2(KLIM) : 1;
    localparam int NCW   = $clog2(MAX_N + 1);
    localparam int KCW   = $clog2(KLIM + 1);
    localparam int KNW   = NCW + KCW;
    localparam int LPW   = (KLIM * MAX_N > 1) ? $clog2(KLIM * MAX_N) : 1;
    localparam int CMPW  = KNW + LPW + 1;
    localparam int VW    = (NCW > KCW) ? NCW : KCW;
    localparam int DEPTH = MAX_K * MAX_N;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW    = 2 * VALUE_BITS;
    localparam logic [AW-1:0] STRIDE = AW'(MAX_N);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_MAC  = 2'd2;

    logic [1:0]            state_reg, state_next;
    logic [ROWS_W-1:0]     m_eff_reg, m_eff_next;
    logic [NCW-1:0]        n_eff_reg, n_eff_next;
    logic [KCW-1:0]        k_eff_reg, k_eff_next;
    logic                  tr_reg, tr_next;
    logic [LPW-1:0]        lp_reg, lp_next;
    logic [KCW-1:0]        ip_reg, ip_next;
    logic [ROWCNT_W-1:0]   rc_reg, rc_next;
    logic [VALUE_BITS-1:0] b_reg, b_next;
    logic signed [VALUE_BITS-1:0] a_reg, a_next;
    logic                  iss_reg, iss_next;
    logic [NW-1:0]         j0_reg, j0_next;
    logic                  v1_reg, v1_next;
    logic [NW-1:0]         col1_reg, col1_next;
    logic                  v2_reg, v2_next;
    logic [NW-1:0]         col2_reg, col2_next;
    logic signed [PW-1:0]  prod_reg, prod_next;
    logic                  fin_reg, fin_next;
    logic                  lrow_reg, lrow_next;
    logic                  out_valid_reg, out_valid_next;
    out_item_t             out_data_reg, out_data_next;

    logic                  s_acc, cfg_acc;
    logic [6:0]            f7;
    logic [KNW-1:0]        kn;
    logic [LPW-1:0]        lp_use;
    logic [LPW:0]          lp_inc;
    logic [KCW-1:0]        ip_inc;
    logic                  adv, consume, col2_last, pass_end, ring_clear;
    logic [SUM_W-1:0]      prod_ext, sum_new, ring_inject;
    logic [SUM_W-1:0]      cell_sum [MAX_N];

    logic                  div_start, div_done;
    logic [LPW-1:0]        div_quot;
    logic [VW-1:0]         div_rem;
    logic [RW-1:0]         w_row;
    logic [NW-1:0]         w_col;

    logic                  ram_we, ram_re;
    logic [AW-1:0]         ram_waddr, ram_raddr;
    logic [VALUE_BITS-1:0] ram_rdata;
    logic signed [VALUE_BITS-1:0] b_s;

    assign s_acc     = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign cfg_acc   = cfg_valid && cfg_ready;
    assign f7        = cfg_data[6:0];

    assign kn     = KNW'(k_eff_reg) * KNW'(n_eff_reg);
    assign lp_use = (CMPW'(lp_reg) >= CMPW'(kn)) ? '0 : lp_reg;
    assign lp_inc = {1'b0, lp_reg} + (LPW + 1)'(1);
    assign ip_inc = ip_reg + KCW'(1);

    assign div_start = s_acc && (s_data.command == CMD_LOAD_B);

    wsmm_div #(
        .DW (LPW),
        .VW (VW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (lp_use),
        .divisor  (tr_reg ? VW'(k_eff_reg) : VW'(n_eff_reg)),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    assign w_row     = tr_reg ? RW'(div_rem) : RW'(div_quot);
    assign w_col     = tr_reg ? NW'(div_quot) : NW'(div_rem);
    assign ram_we    = (state_reg == ST_DIV) && div_done;
    assign ram_waddr = AW'(w_row) * STRIDE + AW'(w_col);
    assign ram_raddr = AW'(ip_reg) * STRIDE + AW'(j0_reg);

    assign adv       = !(v2_reg && fin_reg) || !out_valid_reg || m_ready;
    assign ram_re    = (state_reg == ST_MAC) && adv && iss_reg;
    assign consume   = (state_reg == ST_MAC) && adv && v2_reg;
    assign col2_last = (NCW'(col2_reg) == (n_eff_reg - NCW'(1)));
    assign pass_end  = consume && col2_last;

    wsmm_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (DEPTH)
    ) u_weights (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (b_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign b_s         = signed'(ram_rdata);
    assign prod_next   = (state_reg == ST_MAC && adv) ? PW'(a_reg) * PW'(b_s) : prod_reg;
    assign prod_ext    = {{(SUM_W - PW){prod_reg[PW-1]}}, prod_reg};
    assign sum_new     = cell_sum[0] + prod_ext;
    assign ring_inject = fin_reg ? '0 : sum_new;
    assign ring_clear  = s_acc && (s_data.command == CMD_RESTART);

    for (genvar i = 0; i < MAX_N; i++) begin : g_cell
        cell_ctl_t        ctl;
        logic [SUM_W-1:0] right;

        assign ctl.step  = consume;
        assign ctl.clear = ring_clear;
        assign ctl.tail  = (NCW'(i) == (n_eff_reg - NCW'(1)));
        assign ctl.below = (NCW'(i) < (n_eff_reg - NCW'(1)));

        if (i < MAX_N - 1) begin : g_mid
            assign right = cell_sum[i + 1];
        end else begin : g_end
            assign right = '0;
        end

        wsmm_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctl        (ctl),
            .from_right (right),
            .inject     (ring_inject),
            .sum        (cell_sum[i])
        );
    end

    // configuration, clamped to legal ranges at write time
    always_comb begin
        m_eff_next = m_eff_reg;
        n_eff_next = n_eff_reg;
        k_eff_next = k_eff_reg;
        tr_next    = tr_reg;
        if (cfg_acc) begin
            case (cfg_index)
                REG_ROWS_M: begin
                    if (cfg_data == '0) begin
                        m_eff_next = ROWS_W'(1);
                    end else if (32'(cfg_data) > M_MAX) begin
                        m_eff_next = ROWS_W'(M_MAX);
                    end else begin
                        m_eff_next = cfg_data;
                    end
                end
                REG_COLS_N: begin
                    if (f7 == '0) begin
                        n_eff_next = NCW'(1);
                    end else if (32'(f7) > MAX_N) begin
                        n_eff_next = NCW'(MAX_N);
                    end else begin
                        n_eff_next = NCW'(f7);
                    end
                end
                REG_INNER_K: begin
                    if (f7 == '0) begin
                        k_eff_next = KCW'(1);
                    end else if (32'(f7) > KLIM) begin
                        k_eff_next = KCW'(KLIM);
                    end else begin
                        k_eff_next = KCW'(f7);
                    end
                end
                REG_TRANSPOSE_B: begin
                    tr_next = cfg_data[0];
                end
                default: begin
                    tr_next = tr_reg;
                end
            endcase
        end
    end

    always_comb begin
        state_next     = state_reg;
        lp_next        = lp_reg;
        ip_next        = ip_reg;
        rc_next        = rc_reg;
        b_next         = b_reg;
        a_next         = a_reg;
        iss_next       = iss_reg;
        j0_next        = j0_reg;
        v1_next        = v1_reg;
        col1_next      = col1_reg;
        v2_next        = v2_reg;
        col2_next      = col2_reg;
        fin_next       = fin_reg;
        lrow_next      = lrow_reg;
        out_valid_next = (out_valid_reg && m_ready) ? 1'b0 : out_valid_reg;
        out_data_next  = out_data_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    case (s_data.command)
                        CMD_LOAD_B: begin
                            lp_next    = lp_use;
                            b_next     = s_data.value;
                            state_next = ST_DIV;
                        end
                        CMD_A_ELEM: begin
                            a_next     = s_data.value;
                            iss_next   = 1'b1;
                            j0_next    = '0;
                            fin_next   = ip_inc >= k_eff_reg;
                            lrow_next  = (ROWS_W'(rc_reg) + ROWS_W'(1)) >= m_eff_reg;
                            state_next = ST_MAC;
                        end
                        CMD_RESTART: begin
                            lp_next = '0;
                            ip_next = '0;
                            rc_next = '0;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    lp_next    = (CMPW'(lp_inc) >= CMPW'(kn)) ? '0 : LPW'(lp_inc);
                    state_next = ST_IDLE;
                end
            end
            ST_MAC: begin
                if (adv) begin
                    v1_next   = iss_reg;
                    col1_next = j0_reg;
                    v2_next   = v1_reg;
                    col2_next = col1_reg;
                    if (iss_reg) begin
                        if (NCW'(j0_reg) == (n_eff_reg - NCW'(1))) begin
                            iss_next = 1'b0;
                        end else begin
                            j0_next = j0_reg + NW'(1);
                        end
                    end
                end
                if (consume && fin_reg) begin
                    out_valid_next               = 1'b1;
                    out_data_next.column         = COL_W'(col2_reg);
                    out_data_next.sum            = signed'(sum_new);
                    out_data_next.last_of_row    = col2_last;
                    out_data_next.last_of_matrix = col2_last && lrow_reg;
                end
                if (pass_end) begin
                    state_next = ST_IDLE;
                    if (fin_reg) begin
                        ip_next = '0;
                        rc_next = lrow_reg ? '0 : rc_reg + ROWCNT_W'(1);
                    end else begin
                        ip_next = ip_inc;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_eff_reg     <= ROWS_W'(1);
            n_eff_reg     <= NCW'(1);
            k_eff_reg     <= KCW'(1);
            tr_reg        <= 1'b0;
            lp_reg        <= '0;
            ip_reg        <= '0;
            rc_reg        <= '0;
            iss_reg       <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            m_eff_reg     <= m_eff_next;
            n_eff_reg     <= n_eff_next;
            k_eff_reg     <= k_eff_next;
            tr_reg        <= tr_next;
            lp_reg        <= lp_next;
            ip_reg        <= ip_next;
            rc_reg        <= rc_next;
            iss_reg       <= iss_next;
            v1_reg        <= v1_next;
            v2_reg        <= v2_next;
            out_valid_reg <= out_valid_next;
        end
        b_reg        <= b_next;
        a_reg        <= a_next;
        j0_reg       <= j0_next;
        col1_reg     <= col1_next;
        col2_reg     <= col2_next;
        prod_reg     <= prod_next;
        fin_reg      <= fin_next;
        lrow_reg     <= lrow_next;
        out_data_reg <= out_data_next;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    `WSMM_CHECK(a_div_in_load, div_done, state_reg == ST_DIV, "divider finished outside a B load")
    `WSMM_CHECK(a_ram_one_port, ram_we, !ram_re, "weight write and read in the same cycle")
    `WSMM_CHECK(a_matrix_end, m_valid && m_data.last_of_matrix, m_data.last_of_row, "matrix end not at row end")
    `WSMM_CHECK_NEXT(a_row_wrap, pass_end && fin_reg, ip_reg == '0, "inner position not cleared after row")

endmodule

`default_nettype wire

FILE: tb/sv/weight_stationary_matrix_multiply_tb.sv
// Testbench for weight_stationary_matrix_multiply: loads B, streams A rows and restarts
// under random sender and receiver stalls, predicting each result row in a scoreboard.
// Depends on wsmm_pkg and the weight_stationary_matrix_multiply RTL; reads no files.

module weight_stationary_matrix_multiply_tb;
    import wsmm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int WEIGHT_DEPTH  = MAX_K_DEF * MAX_N_DEF;
    localparam int DRAIN_CYCLES  = 80;
    localparam int TOTAL_ITEMS   = 220;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    class matmul_scoreboard;
        int unsigned rows_reg, cols_reg, inner_reg;
        bit          transpose_reg;
        logic signed [VALUE_BITS-1:0] weights [WEIGHT_DEPTH];
        bit                           written [WEIGHT_DEPTH];
        logic signed [SUM_W-1:0]      acc [MAX_N_DEF];
        int unsigned load_pos, inner_pos, row_cnt;
        out_item_t   row_results_q[$];
        int unsigned errors, checked, loads, elems, restarts, rows_done;

        function new();
            rows_reg = 1;
            cols_reg = 1;
            inner_reg = 1;
            transpose_reg = 1'b0;
            foreach (written[i]) written[i] = 1'b0;
            clear_counters();
        endfunction

        function void clear_counters();
            foreach (acc[j]) acc[j] = '0;
            load_pos = 0;
            inner_pos = 0;
            row_cnt = 0;
        endfunction

        function int unsigned clamp(int unsigned v, int unsigned hi);
            if (v < 1) return 1;
            if (v > hi) return hi;
            return v;
        endfunction

        function int unsigned eff_m();
            return clamp(rows_reg, M_MAX);
        endfunction

        function int unsigned eff_n();
            return clamp(cols_reg, MAX_N_DEF);
        endfunction

        function int unsigned eff_k();
            return clamp(inner_reg, MAX_K_DEF);
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_ROWS_M:      rows_reg = data[12:0];
                REG_COLS_N:      cols_reg = data[6:0];
                REG_INNER_K:     inner_reg = data[6:0];
                REG_TRANSPOSE_B: transpose_reg = data[0];
                default: ;
            endcase
        endfunction

        // next A element only reads weights that have been loaded
        function bit a_ready();
            int unsigned p;
            p = inner_pos % MAX_K_DEF;
            for (int unsigned j = 0; j < eff_n(); j++)
                if (!written[p * MAX_N_DEF + j]) return 1'b0;
            return 1'b1;
        endfunction

        function void note_input(in_item_t item);
            int unsigned n, k, m, row, col, p;
            logic signed [SUM_W-1:0] a_wide, b_wide;
            out_item_t res;
            n = eff_n();
            k = eff_k();
            m = eff_m();
            case (item.command)
                CMD_RESTART: begin
                    restarts++;
                    clear_counters();
                end
                CMD_LOAD_B: begin
                    loads++;
                    if (load_pos >= k * n) load_pos = 0;
                    if (transpose_reg) begin
                        col = load_pos / k;
                        row = load_pos % k;
                    end else begin
                        row = load_pos / n;
                        col = load_pos % n;
                    end
                    p = (row % MAX_K_DEF) * MAX_N_DEF + (col % MAX_N_DEF);
                    weights[p] = item.value;
                    written[p] = 1'b1;
                    load_pos++;
                    if (load_pos >= k * n) load_pos = 0;
                end
                CMD_A_ELEM: begin
                    elems++;
                    p = inner_pos % MAX_K_DEF;
                    a_wide = item.value;
                    for (int unsigned j = 0; j < n; j++) begin
                        b_wide = weights[p * MAX_N_DEF + j];
                        acc[j] = acc[j] + a_wide * b_wide;
                    end
                    inner_pos++;
                    if (inner_pos >= k) begin
                        for (int unsigned j = 0; j < n; j++) begin
                            res.column         = COL_W'(j);
                            res.sum            = acc[j];
                            res.last_of_row    = (j + 1 == n);
                            res.last_of_matrix = (j + 1 == n) && (row_cnt + 1 >= m);
                            row_results_q.push_back(res);
                            acc[j] = '0;
                        end
                        rows_done++;
                        inner_pos = 0;
                        row_cnt = (row_cnt + 1 >= m) ? 0 : row_cnt + 1;
                    end
                end
                default: ;
            endcase
        endfunction

        function void compare(string field, logic signed [63:0] want,
                              logic signed [63:0] got_v);
            if (got_v !== want) begin
                $error("%s: expected %0d, actual %0d", field, want, got_v);
                errors++;
            end
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            checked++;
            if (row_results_q.size() == 0) begin
                $error("result transfer with none expected: column %0d, sum %0d",
                       got.column, got.sum);
                errors++;
                return;
            end
            want = row_results_q.pop_front();
            compare("column", want.column, got.column);
            compare("sum", want.sum, got.sum);
            compare("last_of_row", want.last_of_row, got.last_of_row);
            compare("last_of_matrix", want.last_of_matrix, got.last_of_matrix);
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    in_item_t              s_data = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    out_item_t             m_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    matmul_scoreboard sb = new();
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned items_sent = 0;
    int unsigned phases = 0;
    int unsigned settings = 0;

    weight_stationary_matrix_multiply dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_data);
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic void set_idle(idle_mode_t mode);
        send_idle_pct  = (mode == IDLE_SENDER) ? 77 : (mode == IDLE_BOTH) ? 29 : 0;
        recv_stall_pct = (mode == IDLE_RECEIVER) ? 77 : (mode == IDLE_BOTH) ? 29 : 0;
    endfunction

    function automatic logic [VALUE_BITS-1:0] pick_value();
        case ($urandom_range(9))
            0: return {1'b0, {(VALUE_BITS - 1){1'b1}}};
            1: return {1'b1, {(VALUE_BITS - 1){1'b0}}};
            2: return '0;
            3: return '1;
            default: return VALUE_BITS'($urandom);
        endcase
    endfunction

    task automatic send(input logic [CMD_W-1:0] cmd, input logic [VALUE_BITS-1:0] value);
        in_item_t item;
        item.command = cmd;
        item.value   = value;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_input(item);
        if (cmd != CMD_UNUSED) items_sent++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (sb.row_results_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] m_raw, n_raw, k_raw,
                             input logic tr);
        logic [CFG_DATA_W-1:0] vals [4];
        vals[REG_ROWS_M]      = m_raw;
        vals[REG_COLS_N]      = {6'($urandom), n_raw[6:0]};
        vals[REG_INNER_K]     = {6'($urandom), k_raw[6:0]};
        vals[REG_TRANSPOSE_B] = {12'($urandom), tr};
        for (int i = 0; i < 4; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data  <= vals[i];
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            sb.set_reg(CFG_IDX_W'(i), vals[i]);
        end
        cfg_valid <= 1'b0;
        settings++;
    endtask

    // new setting, full B load, then rows of A with some noise mixed in
    task automatic run_phase(input logic [CFG_DATA_W-1:0] m_raw, n_raw, k_raw,
                             input logic tr, input int rows);
        set_idle(idle_mode_t'(phases % 4));
        phases++;
        configure(m_raw, n_raw, k_raw, tr);
        if ($urandom_range(2) != 0) send(CMD_RESTART, pick_value());
        repeat (sb.eff_k() * sb.eff_n()) send(CMD_LOAD_B, pick_value());
        repeat (rows) begin
            repeat (sb.eff_k()) begin
                if ($urandom_range(99) < 8) begin
                    case ($urandom_range(2))
                        0: send(CMD_RESTART, pick_value());
                        1: send(CMD_UNUSED, pick_value());
                        default: send(CMD_LOAD_B, pick_value());
                    endcase
                end
                if (sb.a_ready()) send(CMD_A_ELEM, pick_value());
                else send(CMD_RESTART, pick_value());
            end
        end
        // leave a partial row behind for the next setting now and then
        if ($urandom_range(3) == 0) begin
            repeat ($urandom_range(1, 3))
                if (sb.a_ready()) send(CMD_A_ELEM, pick_value());
        end
        wait_drained();
    endtask

    initial begin
        logic [CFG_DATA_W-1:0] m_raw, n_raw, k_raw;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        set_idle(IDLE_NONE);

        // 2x2 product with extreme values, one B overload, ignored command, restart mid-row
        configure(13'd2, 13'd2, 13'd2, 1'b0);
        send(CMD_LOAD_B, 16'h7FFF);
        send(CMD_LOAD_B, 16'h8000);
        send(CMD_LOAD_B, 16'h8000);
        send(CMD_LOAD_B, 16'h0001);
        send(CMD_LOAD_B, 16'hFFFF);
        send(CMD_A_ELEM, 16'h7FFF);
        send(CMD_A_ELEM, 16'h8000);
        send(CMD_A_ELEM, 16'h8000);
        send(CMD_A_ELEM, 16'h8000);
        send(CMD_UNUSED, 16'h5555);
        send(CMD_A_ELEM, 16'h0001);
        send(CMD_RESTART, 16'hAAAA);
        send(CMD_A_ELEM, 16'h7FFF);
        send(CMD_A_ELEM, 16'hFFFF);
        wait_drained();

        // register extremes, including out-of-range values
        run_phase(13'd8191, 13'd127, 13'd0, 1'b0, 2);
        run_phase(13'd0, 13'd0, 13'd127, 1'b1, 1);

        while (items_sent < TOTAL_ITEMS) begin
            m_raw = ($urandom_range(7) == 0) ? 13'($urandom) : 13'($urandom_range(1, 4));
            n_raw = ($urandom_range(9) == 0) ? 13'd0 : 13'($urandom_range(1, 4));
            k_raw = ($urandom_range(9) == 0) ? 13'd0 : 13'($urandom_range(1, 4));
            run_phase(m_raw, n_raw, k_raw, 1'($urandom), $urandom_range(1, 4));
        end

        $display("Ran %0d settings: %0d B loads, %0d A elements, %0d restarts.",
                 settings, sb.loads, sb.elems, sb.restarts);
        $display("Checked %0d result transfers over %0d rows; %0d errors.",
                 sb.checked, sb.rows_done, sb.errors);
        if (sb.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
